// ----- rtl/dra_pkg.sv -----
`timescale 1ns / 1ps

package dra_pkg;

  // Register indexes of the configuration channel.
  localparam logic [1:0] CFG_WORK_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_STAKE_LIMIT = 2'd1;

  // Reset value of both limit shift registers.
  localparam logic [7:0] LIMIT_ZERO_BITS_RST = 8'd20;

  // Spacing used when the timestamps run backward.
  localparam logic [31:0] TARGET_SPACING = 32'd120;
  // Base of the multiplier: (interval - 1) * spacing.
  localparam logic [33:0] MULT_BASE = 34'd1680;

  // Side information that travels with an item down the pipeline.
  typedef struct packed {
    logic       has_last;
    logic [7:0] zero_bits;
  } side_t;

endpackage

// ----- rtl/dra_intf.sv -----
`timescale 1ns / 1ps

// Input request channel.
interface dra_in_if;
  logic        valid;
  logic        ready;
  logic        has_last_block;
  logic        use_stake_limit;
  logic [31:0] last_compact;
  logic [31:0] last_time;
  logic [31:0] prior_time;

  modport source (output valid, has_last_block, use_stake_limit, last_compact,
                  last_time, prior_time, input ready);
  modport sink (input valid, has_last_block, use_stake_limit, last_compact,
                last_time, prior_time, output ready);
endinterface

// Result channel.
interface dra_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_compact;

  modport source (output valid, next_compact, input ready);
  modport sink (input valid, next_compact, output ready);
endinterface

// Configuration write channel.
interface dra_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/dra_front.sv -----
`timescale 1ns / 1ps

module dra_front (
  input  logic           clk_i,
  input  logic           en_i,
  input  dra_pkg::side_t side_i,
  input  logic [31:0]    last_compact_i,
  input  logic [31:0]    last_time_i,
  input  logic [31:0]    prior_time_i,
  output logic [56:0]    prod_o,
  output logic [7:0]     size_o,
  output dra_pkg::side_t side_o
);
  import dra_pkg::*;

  logic [32:0] diff;
  logic [31:0] spacing;
  logic [33:0] mult_d, mult_q;
  logic [7:0]  size_d, size_a_q, size_b_q;
  logic [22:0] word;
  logic [4:0]  rsh;
  logic [22:0] x_d, x_q;
  logic [56:0] prod_d, prod_q;
  side_t       side_a_q, side_b_q;

  // Spacing and multiplier; a negative spacing falls back to the target.
  always_comb begin
    diff    = {1'b0, last_time_i} - {1'b0, prior_time_i};
    spacing = diff[32] ? TARGET_SPACING : diff[31:0];
    mult_d  = MULT_BASE + {1'b0, spacing, 1'b0};
  end

  // Expand the mantissa; small exponents shift it right here, large ones later.
  always_comb begin
    size_d = last_compact_i[31:24];
    word   = last_compact_i[22:0];
    rsh    = {2'd3 - size_d[1:0], 3'b000};
    x_d    = (size_d <= 8'd3) ? (word >> rsh) : word;
  end

  // First stage: decoded operands.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= x_d;
      mult_q   <= mult_d;
      size_a_q <= size_d;
      side_a_q <= side_i;
    end
  end

  // Second stage: mantissa times multiplier.
  assign prod_d = 57'(x_q) * 57'(mult_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      size_b_q <= size_a_q;
      side_b_q <= side_a_q;
    end
  end

  assign prod_o = prod_q;
  assign size_o = size_b_q;
  assign side_o = side_b_q;

endmodule

// ----- rtl/dra_div15.sv -----
`timescale 1ns / 1ps

// Five nibble steps of a long division by fifteen.
module dra_div15 (
  input  logic [3:0]  rem_i,
  input  logic [19:0] dig_i,
  output logic [19:0] quo_o,
  output logic [3:0]  rem_o
);

  // Each step: 16*r + d = 15*r + (r + d), and r + d stays below 30.
  always_comb begin
    logic [3:0] r;
    logic [4:0] sum;
    r     = rem_i;
    quo_o = '0;
    for (int k = 4; k >= 0; k--) begin
      sum = {1'b0, r} + {1'b0, dig_i[4*k +: 4]};
      if (sum >= 5'd15) begin
        quo_o[4*k +: 4] = r + 4'd1;
        r               = 4'(sum - 5'd15);
      end else begin
        quo_o[4*k +: 4] = r;
        r               = sum[3:0];
      end
    end
    rem_o = r;
  end

endmodule

// ----- rtl/dra_pack.sv -----
`timescale 1ns / 1ps

// Limit check and compact encoding of q = (a << t) | repeat(b, t).
module dra_pack (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [59:0]    quo_i,
  input  logic [3:0]     rem_i,
  input  logic [7:0]     tail_i,
  input  dra_pkg::side_t side_i,
  output logic [31:0]    next_compact_o
);
  import dra_pkg::*;

  logic [6:0]  la;
  logic [1:0]  lzb;
  logic [8:0]  bits_q_val;
  logic [8:0]  lim_n;
  logic        use_lim_d, use_lim_q;
  logic [8:0]  n_d, n_q;
  logic [5:0]  size_d, size_q;
  logic [59:0] a_q;
  logic [3:0]  b_q;
  logic [7:0]  t_q;
  logic [23:0] mant;
  logic [7:0]  size8;

  // Bit length of the quotient, from its two parts.
  always_comb begin
    la = '0;
    for (int i = 0; i < 60; i++) begin
      if (quo_i[i]) la = 7'(i + 1);
    end
    lzb = rem_i[3] ? 2'd0 : rem_i[2] ? 2'd1 : rem_i[1] ? 2'd2 : 2'd3;
    if (quo_i != '0) bits_q_val = {2'b0, la} + {1'b0, tail_i};
    else if (rem_i != '0 && tail_i > {6'b0, lzb}) bits_q_val = {1'b0, tail_i} - {7'b0, lzb};
    else bits_q_val = '0;
  end

  // No last block, zero or over the limit takes the limit, whose length is 256 - zero_bits.
  always_comb begin
    lim_n     = 9'd256 - {1'b0, side_i.zero_bits};
    use_lim_d = !side_i.has_last || bits_q_val == '0 || bits_q_val > lim_n;
    n_d       = use_lim_d ? lim_n : bits_q_val;
    size_d    = 6'(({1'b0, n_d} + 10'd7) >> 3);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q       <= quo_i;
      b_q       <= rem_i;
      t_q       <= tail_i;
      use_lim_q <= use_lim_d;
      n_q       <= n_d;
      size_q    <= size_d;
    end
  end

  // Pick the 24-bit mantissa window out of the value bit by bit.
  always_comb begin
    logic signed [10:0] p;
    logic signed [10:0] idx;
    logic [7:0]         ai;
    logic [7:0]         d;
    p    = $signed({2'b0, size_q, 3'b000}) - 11'sd24;
    mant = '0;
    for (int j = 0; j < 24; j++) begin
      idx = p + 11'(j);
      ai  = '0;
      d   = '0;
      if (idx < 0 || idx > 11'sd255) begin
        mant[j] = 1'b0;
      end else if (use_lim_q) begin
        mant[j] = idx[8:0] < n_q;
      end else if (idx[7:0] >= t_q) begin
        ai      = idx[7:0] - t_q;
        mant[j] = (ai < 8'd60) ? a_q[ai[5:0]] : 1'b0;
      end else begin
        d       = t_q - 8'd1 - idx[7:0];
        mant[j] = b_q[2'd3 - d[1:0]];
      end
    end
    size8 = {2'b0, size_q};
    if (mant[23]) begin
      mant  = {8'b0, mant[23:8]};
      size8 = size8 + 8'd1;
    end
    next_compact_o = {size8, mant};
  end

endmodule

// ----- rtl/difficulty_retarget_ema.sv -----
`timescale 1ns / 1ps

// Compact-target retarget unit.
// Requests arrive on in_i (valid/ready) with the last block's compact target,
// its timestamp, the previous timestamp and the stake flag. Each request gives
// exactly one result on out_o (valid/ready): the new compact target.
// Two limit shifts are written on cfg_i (index 0 work, 1 stake); cfg_i is
// always ready and writes to other indexes are dropped.
// Throughput is one request per cycle unless the receiver stalls; the pipeline
// holds seven requests, split into decode, multiply, three long-division
// stages, limit check and the output register holding the packed result.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets both limit shifts to 20.
module difficulty_retarget_ema (
  input  logic clk_i,
  input  logic rst_ni,
  dra_in_if.sink    in_i,
  dra_out_if.source out_o,
  dra_cfg_if.sink   cfg_i
);
  import dra_pkg::*;

  logic [7:0]  work_zb_q, stake_zb_q;
  logic        en;
  logic [6:0]  vld_q;
  side_t       side_in;
  logic [56:0] prod;
  logic [7:0]  size_b;
  side_t       side_b;

  logic [59:0] c_in [3];
  logic [59:0] q_in [3];
  logic [3:0]  r_in [3];
  logic [7:0]  t_in [3];
  side_t       s_in [3];
  logic [19:0] qd   [3];
  logic [59:0] qn   [3];
  logic [3:0]  rn   [3];
  logic [59:0] dc_q [3];
  logic [59:0] dq_q [3];
  logic [3:0]  dr_q [3];
  logic [7:0]  dt_q [3];
  side_t       ds_q [3];

  logic [59:0] c0;
  logic [7:0]  t0;
  logic [31:0] packed_val;
  logic [31:0] out_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_zb_q  <= LIMIT_ZERO_BITS_RST;
      stake_zb_q <= LIMIT_ZERO_BITS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WORK_LIMIT:  work_zb_q  <= cfg_i.data;
        CFG_STAKE_LIMIT: stake_zb_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a result waits on a stalled receiver.
  assign en         = !vld_q[6] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], in_i.valid};
    end
  end

  assign side_in.has_last  = in_i.has_last_block;
  assign side_in.zero_bits = in_i.use_stake_limit ? stake_zb_q : work_zb_q;

  dra_front u_front (
    .clk_i          (clk_i),
    .en_i           (en),
    .side_i         (side_in),
    .last_compact_i (in_i.last_compact),
    .last_time_i    (in_i.last_time),
    .prior_time_i   (in_i.prior_time),
    .prod_o         (prod),
    .size_o         (size_b),
    .side_o         (side_b)
  );

  // Place the product: the low 7 bits of 1920 = 128 * 15 come off as a
  // shift, bits pushed past bit 255 are masked away, and exponents of 35 and above give zero.
  always_comb begin
    logic [7:0] s;
    logic [8:0] keep;
    s    = '0;
    keep = '0;
    c0   = '0;
    t0   = '0;
    if (size_b <= 8'd3) begin
      c0 = 60'(prod >> 7);
    end else if (size_b < 8'd35) begin
      s    = {5'(size_b - 8'd3), 3'b000};
      t0   = s - 8'd7;
      keep = 9'd256 - {1'b0, s};
      for (int i = 0; i < 57; i++) begin
        c0[i] = prod[i] & (9'(i) < keep);
      end
    end
  end

  // Three stages of division by fifteen, five nibbles each.
  for (genvar g = 0; g < 3; g++) begin : g_div
    if (g == 0) begin : g_first
      assign c_in[g] = c0;
      assign q_in[g] = '0;
      assign r_in[g] = '0;
      assign t_in[g] = t0;
      assign s_in[g] = side_b;
    end else begin : g_next
      assign c_in[g] = dc_q[g-1];
      assign q_in[g] = dq_q[g-1];
      assign r_in[g] = dr_q[g-1];
      assign t_in[g] = dt_q[g-1];
      assign s_in[g] = ds_q[g-1];
    end

    dra_div15 u_div (
      .rem_i (r_in[g]),
      .dig_i (c_in[g][59-20*g -: 20]),
      .quo_o (qd[g]),
      .rem_o (rn[g])
    );

    // The new quotient digits fill the slice that is still zero.
    assign qn[g] = q_in[g] | (60'(qd[g]) << (40 - 20*g));

    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[g] <= c_in[g];
        dq_q[g] <= qn[g];
        dr_q[g] <= rn[g];
        dt_q[g] <= t_in[g];
        ds_q[g] <= s_in[g];
      end
    end
  end

  dra_pack u_pack (
    .clk_i          (clk_i),
    .en_i           (en),
    .quo_i          (dq_q[2]),
    .rem_i          (dr_q[2]),
    .tail_i         (dt_q[2]),
    .side_i         (ds_q[2]),
    .next_compact_o (packed_val)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= packed_val;
    end
  end

  assign out_o.valid        = vld_q[6];
  assign out_o.next_compact = out_q;

  // Results never carry the sign bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.next_compact[23])
    else $error("result has sign bit set");

  // The exponent of a result stays at or below 33.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.next_compact[31:24] <= 8'd33)
    else $error("result exponent out of range");

  // Requests are refused only while a result is held by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("request refused without a stall");

  // A taken result with no item behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !vld_q[5] |=> !out_o.valid)
    else $error("result repeated");

endmodule

// ----- tb/dra_test_intf.sv -----
`timescale 1ns / 1ps

// The channel interfaces come with the RTL in rtl/dra_intf.sv, so this file
// holds only a small record type that the directed stimulus table uses.
package dra_test_pkg;

  // One row of directed stimulus; has_gold marks a result typed in by hand.
  typedef struct {
    logic        has_last;
    logic        stake;
    logic [31:0] compact;
    logic [31:0] t_last;
    logic [31:0] t_prior;
    logic        has_gold;
    logic [31:0] gold;
  } dir_row_t;

endpackage

// ----- tb/difficulty_retarget_ema_test.sv -----
`timescale 1ns / 1ps

module difficulty_retarget_ema_test;
  import dra_pkg::*;
  import dra_test_pkg::*;

  localparam int NUM_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dra_in_if  in_ch ();
  dra_out_if out_ch ();
  dra_cfg_if cfg_ch ();

  difficulty_retarget_ema u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always #4 clk_i = ~clk_i;

  // Local copy of the two limit shifts.
  logic [7:0] work_shift;
  logic [7:0] stake_shift;

  logic [31:0] target_queue[$];
  int errors = 0;
  int cycles = 0;
  bit sender_done = 1'b0;

  // Highest set bit position plus one.
  function automatic int bit_len(logic [255:0] a);
    int n;
    n = 0;
    for (int i = 0; i < 256; i++) begin
      if (a[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  // Pack a 256-bit target into compact form.
  function automatic logic [31:0] pack_target(logic [255:0] a);
    int sz;
    logic [255:0] t;
    logic [31:0] mant;
    sz = (bit_len(a) + 7) / 8;
    if (sz <= 3) begin
      mant = a[31:0] << (8 * (3 - sz));
    end else begin
      t = a >> (8 * (sz - 3));
      mant = t[31:0];
    end
    mant = mant & 32'h00ff_ffff;
    if (mant[23]) begin
      mant = mant >> 8;
      sz++;
    end
    return mant | (32'(sz) << 24);
  endfunction

  // Expected compact target for one request.
  function automatic logic [31:0] retarget(logic has_last, logic stake, logic [31:0] compact,
                                           logic [31:0] t_last, logic [31:0] t_prior);
    logic [255:0] lim;
    logic [255:0] v;
    logic [33:0] mult;
    logic [32:0] spacing;
    logic [289:0] prod;
    int unsigned expo;
    lim = {256{1'b1}} >> (stake ? stake_shift : work_shift);
    if (!has_last) begin
      return pack_target(lim);
    end
    spacing = (t_last >= t_prior) ? {1'b0, t_last - t_prior} : 33'd120;
    mult = 34'd1680 + {spacing, 1'b0};
    expo = compact[31:24];
    if (expo <= 3) begin
      v = 256'(compact[22:0] >> (8 * (3 - expo)));
    end else begin
      v = 256'(compact[22:0]) << (8 * (expo - 3));
    end
    prod = 290'(v) * 290'(mult);
    v = prod[255:0] / 256'd1920;
    if (v == '0 || v > lim) begin
      v = lim;
    end
    return pack_target(v);
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, compare every accepted result with the oldest expectation.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (target_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 out_ch.next_compact);
        errors++;
      end else begin
        logic [31:0] exp_c;
        exp_c = target_queue.pop_front();
        if (out_ch.next_compact !== exp_c) begin
          $display("%0t: next_compact mismatch, expected %h, actual %h", $time, exp_c,
                   out_ch.next_compact);
          errors++;
        end
      end
    end
  end

  // Send one request after a random gap; queues the expectation at acceptance.
  // Valid stays high after acceptance until the next gap or the next drain.
  task automatic send_request(logic has_last, logic stake, logic [31:0] compact,
                              logic [31:0] t_last, logic [31:0] t_prior,
                              bit has_gold, logic [31:0] gold);
    int gap;
    logic [31:0] exp_c;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.has_last_block <= has_last;
    in_ch.use_stake_limit <= stake;
    in_ch.last_compact <= compact;
    in_ch.last_time <= t_last;
    in_ch.prior_time <= t_prior;
    do @(posedge clk_i); while (!in_ch.ready);
    exp_c = retarget(has_last, stake, compact, t_last, t_prior);
    if (has_gold && gold !== exp_c) begin
      $display("%0t: directed target mismatch, expected %h, predicted %h", $time, gold,
               exp_c);
      errors++;
    end
    target_queue.push_back(has_gold ? gold : exp_c);
  endtask

  // Write one limit register; the block must be idle.
  task automatic write_limit(logic [1:0] idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WORK_LIMIT) begin
      work_shift = val;
    end else if (idx == CFG_STAKE_LIMIT) begin
      stake_shift = val;
    end
    @(posedge clk_i);
  endtask

  // Drop valid and wait for all outstanding results, then idle before returning.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (target_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random compact value biased toward interesting exponents.
  function automatic logic [31:0] rand_compact();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 3))
      0: c[31:24] = 8'($urandom_range(0, 40));
      1: c[31:24] = 8'($urandom_range(32'h1a, 32'h20));
      default: ;
    endcase
    return c;
  endfunction

  // Random spacing: forward up to 600 s, backward up to 600 s, or fully random.
  task automatic rand_times(output logic [31:0] t_last, output logic [31:0] t_prior);
    t_prior = $urandom;
    case ($urandom_range(0, 3))
      0: t_last = t_prior + $urandom_range(0, 600);
      1: t_last = t_prior - $urandom_range(1, 600);
      default: t_last = $urandom;
    endcase
  endtask

  dir_row_t dir_rows[] = '{
    // No last block: packed limits.
    '{1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h1e0f_ffff},
    '{1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b1, 32'h1e0f_ffff},
    // Zero target turns into the limit.
    '{1'b1, 1'b0, 32'h0, 32'd100, 32'd0, 1'b1, 32'h1e0f_ffff},
    // Exponent 35 and above decodes to zero.
    '{1'b1, 1'b1, 32'h237f_ffff, 32'd300, 32'd180, 1'b1, 32'h1e0f_ffff},
    '{1'b1, 1'b0, 32'hff7f_ffff, 32'd300, 32'd180, 1'b1, 32'h1e0f_ffff},
    // Huge exponent, partial shift out.
    '{1'b1, 1'b0, 32'h227f_ffff, 32'd300, 32'd180, 1'b0, 32'h0},
    // Sign bit set is ignored.
    '{1'b1, 1'b0, 32'h1c80_1234, 32'd1000, 32'd880, 1'b0, 32'h0},
    '{1'b1, 1'b1, 32'h1cff_ffff, 32'd1000, 32'd880, 1'b0, 32'h0},
    // Small exponents.
    '{1'b1, 1'b0, 32'h007f_ffff, 32'd120, 32'd0, 1'b1, 32'h1e0f_ffff},
    '{1'b1, 1'b0, 32'h017f_ffff, 32'd5000, 32'd0, 1'b0, 32'h0},
    '{1'b1, 1'b0, 32'h027f_ffff, 32'd5000, 32'd0, 1'b0, 32'h0},
    '{1'b1, 1'b0, 32'h037f_ffff, 32'd5000, 32'd0, 1'b0, 32'h0},
    '{1'b1, 1'b0, 32'h047f_ffff, 32'd0, 32'd0, 1'b0, 32'h0},
    // Backward timestamps use the nominal spacing.
    '{1'b1, 1'b0, 32'h1b12_3456, 32'd0, 32'hffff_ffff, 1'b0, 32'h0},
    // Largest spacing, product overflow.
    '{1'b1, 1'b0, 32'h207f_ffff, 32'hffff_ffff, 32'h0, 1'b0, 32'h0},
    '{1'b1, 1'b1, 32'h1d7f_ffff, 32'hffff_ffff, 32'h0, 1'b0, 32'h0},
    // Equal timestamps, smallest multiplier; then backward and forward spacing.
    '{1'b1, 1'b1, 32'h1b7f_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0},
    '{1'b1, 1'b0, 32'h1d00_ffff, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'h0},
    '{1'b1, 1'b1, 32'h1d00_ffff, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'h0}
  };

  // Stimulus phases and final verdict.
  initial begin
    logic [31:0] t_last;
    logic [31:0] t_prior;
    logic [7:0] shifts[6] = '{8'd0, 8'd255, 8'd1, 8'd200, 8'd32, 8'd8};
    work_shift = LIMIT_ZERO_BITS_RST;
    stake_shift = LIMIT_ZERO_BITS_RST;
    in_ch.valid = 1'b0;
    in_ch.has_last_block = 1'b0;
    in_ch.use_stake_limit = 1'b0;
    in_ch.last_compact = '0;
    in_ch.last_time = '0;
    in_ch.prior_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WORK_LIMIT;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset limits.
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].has_last, dir_rows[i].stake, dir_rows[i].compact,
                   dir_rows[i].t_last, dir_rows[i].t_prior, dir_rows[i].has_gold,
                   dir_rows[i].gold);
    end
    drain();

    // Limit extremes: shift 255 gives 1, shift 0 gives all ones.
    write_limit(CFG_WORK_LIMIT, 8'd255);
    write_limit(CFG_STAKE_LIMIT, 8'd0);
    write_limit(2'd2, 8'd7);
    write_limit(2'd3, 8'd9);
    send_request(1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0101_0000);
    send_request(1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 1'b1, 32'h2100_ffff);
    send_request(1'b1, 1'b1, 32'h227f_ffff, 32'hffff_ffff, 32'h0, 1'b0, 32'h0);
    send_request(1'b1, 1'b0, 32'h1d00_ffff, 32'd120, 32'd0, 1'b1, 32'h0101_0000);
    drain();

    // Random phases, each with its own limit setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(CFG_WORK_LIMIT, shifts[ph]);
      write_limit(CFG_STAKE_LIMIT, (ph == 5) ? 8'($urandom) : shifts[5 - ph]);
      for (int n = 0; n < NUM_RANDOM / 6; n++) begin
        rand_times(t_last, t_prior);
        send_request(($urandom_range(0, 9) != 0), 1'($urandom), rand_compact(), t_last,
                     t_prior, 1'b0, 32'h0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
